// ===== design/spmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the sine PWM midpoint clamp block.
// Holds the quarter-wave sine entry function used to build the sine ROM.
// No dependencies.
package spmc_pkg;

    // Default table size and angle resolution
    localparam int SINE_TABLE_ENTRIES_DEF = 256;
    localparam int ANGLE_BITS_DEF         = 16;

    // Field and register widths
    localparam int VOLT_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int BUS_W   = 15;
    localparam int MPV_W   = 15;
    localparam int PER_W   = 16;
    localparam int CMP_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int SINE_MAG_W = 15;               // unsigned table entry
    localparam int SIN_W      = 16;               // signed sin / cos, Q1.15
    localparam int PROD_W     = SIN_W + VOLT_W;   // sin * voltage
    localparam int AB_W       = PROD_W + 1;       // alpha / beta
    localparam int PH_W       = 48;               // phase voltage, Q.30
    localparam int W_W        = PH_W + 3;         // doubled, clamped phase

    // Clarke scaling and clamp alignment
    localparam int CLARKE_A_SHIFT  = 15;
    localparam int CLARKE_BC_SHIFT = 14;
    localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
    localparam int MPV_SHIFT       = 30;

    // Duty scaling and division
    localparam int DEN_SHIFT = 31;
    localparam int SCALE_W   = BUS_W + DEN_SHIFT;     // bus_voltage * 2^31
    localparam int SPLIT_W   = 23;
    localparam int HI_W      = SCALE_W - SPLIT_W;
    localparam int PP_W      = SPLIT_W + PER_W;
    localparam int X_W       = SCALE_W + PER_W;
    localparam int REM_W     = X_W - DEN_SHIFT;
    localparam int DIV_STEPS = CMP_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUS_VOLTAGE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PHASE_VOLTAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD        = 2'd2;

    // Register reset values
    localparam logic [BUS_W-1:0] BUS_VOLTAGE_RST       = 15'd3072;
    localparam logic [MPV_W-1:0] MAX_PHASE_VOLTAGE_RST = 15'd3072;
    localparam logic [PER_W-1:0] PWM_PERIOD_RST        = 16'd4096;

    // Sine table generation, Q28 Taylor series
    localparam logic [63:0] PI_Q28    = 64'd843314857;
    localparam int          SINE_FRAC = 28;
    localparam logic [63:0] SINE_MAX  = 64'd32767;
    localparam int          TAYLOR_TERMS = 7;
    localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic [BUS_W-1:0] bus_voltage;
        logic [MPV_W-1:0] max_phase_voltage;
        logic [PER_W-1:0] pwm_period;
    } cfg_t;

    typedef logic signed [W_W-1:0] wval_t;

    // One table entry: round(32767 * sin(x)) with x in Q28 radians
    function automatic logic [SINE_MAG_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x2  = (x * x) >> SINE_FRAC;
        mag = x;
        sum = $signed(x);
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            mag = ((mag * x2) >> SINE_FRAC) / TAYLOR_DIV[n];
            if ((n & 1) != 0) begin
                sum = sum - $signed(mag);
            end else begin
                sum = sum + $signed(mag);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        v = ($unsigned(sum) * SINE_MAX + (64'd1 << (SINE_FRAC - 1))) >> SINE_FRAC;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return v[SINE_MAG_W-1:0];
    endfunction

endpackage

// ===== design/spmc_sincos.sv =====
`timescale 1ns / 1ps
// Angle to sine / cosine: table index, quarter-wave ROM read, quadrant sign.
// Three register stages. Depends on spmc_pkg.
module spmc_sincos #(
    parameter int SINE_TABLE_ENTRIES = spmc_pkg::SINE_TABLE_ENTRIES_DEF,
    parameter int ANGLE_BITS         = spmc_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   in_vld,
    input  logic signed [spmc_pkg::VOLT_W-1:0]     in_vq,
    input  logic signed [spmc_pkg::VOLT_W-1:0]     in_vd,
    input  logic [spmc_pkg::ANGLE_W-1:0]           in_angle,
    output logic                                   out_vld,
    output logic signed [spmc_pkg::VOLT_W-1:0]     out_vq,
    output logic signed [spmc_pkg::VOLT_W-1:0]     out_vd,
    output logic signed [spmc_pkg::SIN_W-1:0]      out_sin,
    output logic signed [spmc_pkg::SIN_W-1:0]      out_cos
);

    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int QP_W  = ANGLE_BITS - 2;
    localparam int PW    = QP_W + IDX_W;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // Quarter-wave ROM, entries 0..N inclusive
    logic [spmc_pkg::SINE_MAG_W-1:0] sine_rom [0:SINE_TABLE_ENTRIES];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] ROM_X =
            (spmc_pkg::PI_Q28 * 64'(k)) / 64'(2 * SINE_TABLE_ENTRIES);
        assign sine_rom[k] = spmc_pkg::sine_entry(ROM_X);
    end

    // Stage 1: split angle into quadrant and table index
    logic [ANGLE_BITS-1:0] ang;
    logic [QP_W-1:0]       part;
    logic [PW-1:0]         prod;
    logic [IDX_W-1:0]      idx_next;

    assign ang      = ANGLE_BITS'(in_angle);
    assign part     = ang[QP_W-1:0];
    assign prod     = PW'(part) * PW'(SINE_TABLE_ENTRIES);
    assign idx_next = prod[PW-1:QP_W];

    logic                                vld1_reg;
    logic [IDX_W-1:0]                    idx1_reg;
    quad_t                               quad1_reg;
    logic signed [spmc_pkg::VOLT_W-1:0]  vq1_reg;
    logic signed [spmc_pkg::VOLT_W-1:0]  vd1_reg;

    // Stage 2: ROM read at both ends of the quarter wave
    logic                                vld2_reg;
    logic [spmc_pkg::SINE_MAG_W-1:0]     lo2_reg;
    logic [spmc_pkg::SINE_MAG_W-1:0]     hi2_reg;
    quad_t                               quad2_reg;
    logic signed [spmc_pkg::VOLT_W-1:0]  vq2_reg;
    logic signed [spmc_pkg::VOLT_W-1:0]  vd2_reg;

    // Stage 3: apply quadrant signs
    logic                                vld3_reg;
    logic signed [spmc_pkg::SIN_W-1:0]   sin3_reg;
    logic signed [spmc_pkg::SIN_W-1:0]   cos3_reg;
    logic signed [spmc_pkg::VOLT_W-1:0]  vq3_reg;
    logic signed [spmc_pkg::VOLT_W-1:0]  vd3_reg;

    logic signed [spmc_pkg::SIN_W-1:0]   lo_s;
    logic signed [spmc_pkg::SIN_W-1:0]   hi_s;
    logic signed [spmc_pkg::SIN_W-1:0]   sin_next;
    logic signed [spmc_pkg::SIN_W-1:0]   cos_next;

    assign lo_s = $signed({1'b0, lo2_reg});
    assign hi_s = $signed({1'b0, hi2_reg});

    always_comb begin
        case (quad2_reg)
            QUAD_I: begin
                sin_next = lo_s;
                cos_next = hi_s;
            end
            QUAD_II: begin
                sin_next = hi_s;
                cos_next = -lo_s;
            end
            QUAD_III: begin
                sin_next = -lo_s;
                cos_next = -hi_s;
            end
            QUAD_IV: begin
                sin_next = -hi_s;
                cos_next = lo_s;
            end
            default: begin
                sin_next = lo_s;
                cos_next = hi_s;
            end
        endcase
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            idx1_reg  <= idx_next;
            quad1_reg <= quad_t'(ang[ANGLE_BITS-1 -: 2]);
            vq1_reg   <= in_vq;
            vd1_reg   <= in_vd;

            lo2_reg   <= sine_rom[idx1_reg];
            hi2_reg   <= sine_rom[IDX_W'(SINE_TABLE_ENTRIES) - idx1_reg];
            quad2_reg <= quad1_reg;
            vq2_reg   <= vq1_reg;
            vd2_reg   <= vd1_reg;

            sin3_reg  <= sin_next;
            cos3_reg  <= cos_next;
            vq3_reg   <= vq2_reg;
            vd3_reg   <= vd2_reg;
        end
    end

    assign out_vld = vld3_reg;
    assign out_sin = sin3_reg;
    assign out_cos = cos3_reg;
    assign out_vq  = vq3_reg;
    assign out_vd  = vd3_reg;

endmodule

// ===== design/spmc_transform.sv =====
`timescale 1ns / 1ps
// Inverse Park and inverse Clarke transforms followed by the midpoint clamp.
// Seven register stages; output is each phase doubled plus the clamp offset.
// Depends on spmc_pkg.
module spmc_transform (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  spmc_pkg::cfg_t                         cfg,
    input  logic                                   in_vld,
    input  logic signed [spmc_pkg::SIN_W-1:0]      in_sin,
    input  logic signed [spmc_pkg::SIN_W-1:0]      in_cos,
    input  logic signed [spmc_pkg::VOLT_W-1:0]     in_vq,
    input  logic signed [spmc_pkg::VOLT_W-1:0]     in_vd,
    output logic                                   out_vld,
    output spmc_pkg::wval_t                        out_w [3]
);

    localparam int PROD_W = spmc_pkg::PROD_W;
    localparam int AB_W   = spmc_pkg::AB_W;
    localparam int PH_W   = spmc_pkg::PH_W;
    localparam int W_W    = spmc_pkg::W_W;

    logic [6:0] vld_reg;

    // Stage 1: four products
    logic signed [PROD_W-1:0] cd_reg, sq_reg, sd_reg, cq_reg;
    // Stage 2: alpha / beta
    logic signed [AB_W-1:0]   alpha_reg, beta_reg;
    // Stage 3: Clarke scaling terms
    logic signed [PH_W-1:0]   pha_reg, am_reg, bm_reg;
    // Stage 4: three phases
    logic signed [PH_W-1:0]   ph4_reg [3];
    // Stage 5: extremes
    logic signed [PH_W-1:0]   ph5_reg [3];
    logic signed [PH_W-1:0]   mx_reg, mn_reg;
    // Stage 6: clamp offset
    logic signed [PH_W-1:0]   ph6_reg [3];
    logic signed [W_W-1:0]    shift_reg;
    // Stage 7: clamped phases
    spmc_pkg::wval_t          w_reg [3];

    logic signed [PH_W-1:0]   mx_next, mn_next;
    logic signed [W_W-1:0]    shift_next;
    logic signed [W_W-1:0]    center;

    // Pick largest and smallest phase
    always_comb begin
        mx_next = ph4_reg[0];
        mn_next = ph4_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (ph4_reg[i] > mx_next) begin
                mx_next = ph4_reg[i];
            end
            if (ph4_reg[i] < mn_next) begin
                mn_next = ph4_reg[i];
            end
        end
    end

    // Clamp offset: centre target minus (max + min)
    assign center     = $signed(W_W'({cfg.max_phase_voltage, spmc_pkg::MPV_SHIFT'(0)}));
    assign shift_next = center - (W_W'(mx_reg) + W_W'(mn_reg));

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            cd_reg    <= PROD_W'(in_cos) * PROD_W'(in_vd);
            sq_reg    <= PROD_W'(in_sin) * PROD_W'(in_vq);
            sd_reg    <= PROD_W'(in_sin) * PROD_W'(in_vd);
            cq_reg    <= PROD_W'(in_cos) * PROD_W'(in_vq);

            alpha_reg <= AB_W'(cd_reg) - AB_W'(sq_reg);
            beta_reg  <= AB_W'(sd_reg) + AB_W'(cq_reg);

            pha_reg   <= PH_W'(alpha_reg) <<< spmc_pkg::CLARKE_A_SHIFT;
            am_reg    <= PH_W'(alpha_reg) <<< spmc_pkg::CLARKE_BC_SHIFT;
            bm_reg    <= PH_W'(beta_reg) * PH_W'(spmc_pkg::SQRT3_HALF_Q15);

            ph4_reg[0] <= pha_reg;
            ph4_reg[1] <= bm_reg - am_reg;
            ph4_reg[2] <= -am_reg - bm_reg;

            ph5_reg   <= ph4_reg;
            mx_reg    <= mx_next;
            mn_reg    <= mn_next;

            ph6_reg   <= ph5_reg;
            shift_reg <= shift_next;

            for (int i = 0; i < 3; i++) begin
                w_reg[i] <= (W_W'(ph6_reg[i]) <<< 1) + shift_reg;
            end
        end
    end

    assign out_vld = vld_reg[6];
    assign out_w   = w_reg;

endmodule

// ===== design/spmc_duty.sv =====
`timescale 1ns / 1ps
// Duty scaling per phase: saturate against the bus voltage, scale by the PWM
// period and divide with a 16-step pipelined restoring divider. Depends on spmc_pkg.
module spmc_duty (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  spmc_pkg::cfg_t                 cfg,
    input  logic                           in_vld,
    input  spmc_pkg::wval_t                in_w [3],
    output logic                           out_vld,
    output logic [spmc_pkg::CMP_W-1:0]     out_cmp [3]
);

    localparam int W_W       = spmc_pkg::W_W;
    localparam int SCALE_W   = spmc_pkg::SCALE_W;
    localparam int SPLIT_W   = spmc_pkg::SPLIT_W;
    localparam int HI_W      = spmc_pkg::HI_W;
    localparam int PP_W      = spmc_pkg::PP_W;
    localparam int X_W       = spmc_pkg::X_W;
    localparam int REM_W     = spmc_pkg::REM_W;
    localparam int CMP_W     = spmc_pkg::CMP_W;
    localparam int DIV_STEPS = spmc_pkg::DIV_STEPS;

    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_FULL = 2'd1,
        CLS_DIV  = 2'd2
    } duty_cls_t;

    logic                 vld1_reg;
    logic                 vld2_reg;
    logic [DIV_STEPS:0]   vld_div_reg;
    logic [W_W-1:0]       den_ext;

    assign den_ext = W_W'({cfg.bus_voltage, spmc_pkg::DEN_SHIFT'(0)});

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld_div_reg <= '0;
        end else if (adv) begin
            vld1_reg    <= in_vld;
            vld2_reg    <= vld1_reg;
            vld_div_reg <= {vld_div_reg[DIV_STEPS-1:0], vld2_reg};
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        // Stage 1: classify against zero and full scale
        duty_cls_t            cls1_reg;
        logic [SCALE_W-1:0]   wl1_reg;
        duty_cls_t            cls_next;

        // Stage 2: partial products with the period
        duty_cls_t            cls2_reg;
        logic [PP_W-1:0]      phi_reg;
        logic [PP_W-1:0]      plo_reg;

        // Divider pipeline, index 0 holds the scaled dividend
        logic [REM_W-1:0]     rem_reg [0:DIV_STEPS];
        logic [CMP_W-1:0]     q_reg   [0:DIV_STEPS];
        duty_cls_t            cls_reg [0:DIV_STEPS];

        logic [X_W-1:0]       x_sum;
        logic [REM_W-1:0]     dsh      [1:DIV_STEPS];
        logic [REM_W-1:0]     rem_next [1:DIV_STEPS];
        logic [CMP_W-1:0]     q_next   [1:DIV_STEPS];

        always_comb begin
            if (in_w[l][W_W-1] || (in_w[l] == '0)) begin
                cls_next = CLS_ZERO;
            end else if ($unsigned(in_w[l]) >= den_ext) begin
                cls_next = CLS_FULL;
            end else begin
                cls_next = CLS_DIV;
            end
        end

        // Rejoin partial products; the quotient only needs bits above 2^31
        assign x_sum = (X_W'(phi_reg) << SPLIT_W) + X_W'(plo_reg);

        // One quotient bit per stage, most significant first
        always_comb begin
            for (int j = 1; j <= DIV_STEPS; j++) begin
                dsh[j]    = REM_W'(cfg.bus_voltage) << (DIV_STEPS - j);
                q_next[j] = q_reg[j-1];
                if (rem_reg[j-1] >= dsh[j]) begin
                    rem_next[j] = rem_reg[j-1] - dsh[j];
                    q_next[j][DIV_STEPS - j] = 1'b1;
                end else begin
                    rem_next[j] = rem_reg[j-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cls1_reg   <= cls_next;
                wl1_reg    <= in_w[l][SCALE_W-1:0];

                cls2_reg   <= cls1_reg;
                phi_reg    <= PP_W'(wl1_reg[SCALE_W-1 -: HI_W]) * PP_W'(cfg.pwm_period);
                plo_reg    <= PP_W'(wl1_reg[SPLIT_W-1:0]) * PP_W'(cfg.pwm_period);

                rem_reg[0] <= x_sum[X_W-1:spmc_pkg::DEN_SHIFT];
                q_reg[0]   <= '0;
                cls_reg[0] <= cls2_reg;

                for (int j = 1; j <= DIV_STEPS; j++) begin
                    rem_reg[j] <= rem_next[j];
                    q_reg[j]   <= q_next[j];
                    cls_reg[j] <= cls_reg[j-1];
                end
            end
        end

        // Select the compare count from the class
        always_comb begin
            case (cls_reg[DIV_STEPS])
                CLS_ZERO: out_cmp[l] = '0;
                CLS_FULL: out_cmp[l] = cfg.pwm_period;
                CLS_DIV:  out_cmp[l] = q_reg[DIV_STEPS];
                default:  out_cmp[l] = '0;
            endcase
        end
    end

    assign out_vld = vld_div_reg[DIV_STEPS];

endmodule

// ===== design/sine_pwm_midpoint_clamp.sv =====
`timescale 1ns / 1ps
// Sine PWM with midpoint clamp: from input to m_tvalid a transaction passes 3 sine,
// 7 transform, 19 duty stages and the output register. Throughput is one transaction
// per cycle while the skid entry is free; the 16-step divider pipeline sets depth.
// An output register plus one skid entry let input continue while a result waits.
// aresetn (synchronous) clears all valid flags and loads register defaults.
// Depends on spmc_pkg, spmc_sincos, spmc_transform and spmc_duty.
module sine_pwm_midpoint_clamp #(
    parameter int SINE_TABLE_ENTRIES = spmc_pkg::SINE_TABLE_ENTRIES_DEF,
    parameter int ANGLE_BITS         = spmc_pkg::ANGLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input: voltage_q [15:0], voltage_d [31:16], electrical_angle [47:32]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,
    // Output: compare_a [15:0], compare_b [31:16], compare_c [47:32]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [47:0]                          m_tdata,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int VOLT_W = spmc_pkg::VOLT_W;
    localparam int SIN_W  = spmc_pkg::SIN_W;
    localparam int CMP_W  = spmc_pkg::CMP_W;
    localparam int OUT_W  = 3 * CMP_W;

    spmc_pkg::cfg_t cfg_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bus_voltage       <= spmc_pkg::BUS_VOLTAGE_RST;
            cfg_reg.max_phase_voltage <= spmc_pkg::MAX_PHASE_VOLTAGE_RST;
            cfg_reg.pwm_period        <= spmc_pkg::PWM_PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                spmc_pkg::REG_BUS_VOLTAGE:
                    cfg_reg.bus_voltage <= cfg_data[spmc_pkg::BUS_W-1:0];
                spmc_pkg::REG_MAX_PHASE_VOLTAGE:
                    cfg_reg.max_phase_voltage <= cfg_data[spmc_pkg::MPV_W-1:0];
                spmc_pkg::REG_PWM_PERIOD:
                    cfg_reg.pwm_period <= cfg_data[spmc_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the skid entry is free
    logic adv;
    logic skid_vld_reg;
    assign adv      = !skid_vld_reg;
    assign s_tready = adv;

    logic                      sc_vld;
    logic signed [VOLT_W-1:0]  sc_vq, sc_vd;
    logic signed [SIN_W-1:0]   sc_sin, sc_cos;

    spmc_sincos #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .ANGLE_BITS         (ANGLE_BITS)
    ) u_sincos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (s_tvalid),
        .in_vq    ($signed(s_tdata[15:0])),
        .in_vd    ($signed(s_tdata[31:16])),
        .in_angle (s_tdata[47:32]),
        .out_vld  (sc_vld),
        .out_vq   (sc_vq),
        .out_vd   (sc_vd),
        .out_sin  (sc_sin),
        .out_cos  (sc_cos)
    );

    logic             xf_vld;
    spmc_pkg::wval_t  xf_w [3];

    spmc_transform u_transform (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg_reg),
        .in_vld  (sc_vld),
        .in_sin  (sc_sin),
        .in_cos  (sc_cos),
        .in_vq   (sc_vq),
        .in_vd   (sc_vd),
        .out_vld (xf_vld),
        .out_w   (xf_w)
    );

    logic              dt_vld;
    logic [CMP_W-1:0]  dt_cmp [3];

    spmc_duty u_duty (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg_reg),
        .in_vld  (xf_vld),
        .in_w    (xf_w),
        .out_vld (dt_vld),
        .out_cmp (dt_cmp)
    );

    // Output register with one skid entry
    logic [OUT_W-1:0] exit_data;
    logic             m_vld_reg, m_vld_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic             skid_vld_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;

    assign exit_data = {dt_cmp[2], dt_cmp[1], dt_cmp[0]};

    always_comb begin
        m_vld_next     = m_vld_reg;
        m_data_next    = m_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (!skid_vld_reg) begin
            if (!m_vld_reg || m_tready) begin
                m_vld_next  = dt_vld;
                m_data_next = exit_data;
            end else if (dt_vld) begin
                skid_vld_next  = 1'b1;
                skid_data_next = exit_data;
            end
        end else if (m_tready) begin
            m_vld_next    = 1'b1;
            m_data_next   = skid_data_reg;
            skid_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            m_vld_reg    <= m_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sine_pwm_midpoint_clamp: streams voltage and angle
// transactions, predicts the three PWM compare counts and checks results in order.
// Depends on spmc_pkg and the sine_pwm_midpoint_clamp RTL.
module tb_top;

    localparam int     TAB_N          = spmc_pkg::SINE_TABLE_ENTRIES_DEF;
    localparam int     ANG_BITS       = spmc_pkg::ANGLE_BITS_DEF;
    localparam longint unsigned PI_Q28_TB = 64'd843314857;
    localparam longint SQRT3_HALF     = 28378;
    localparam logic [spmc_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int     NUM_PHASES     = 8;
    localparam int     RAND_PER_PHASE = 130;
    localparam int     STALL_LIMIT    = 2000;
    localparam int     TAIL_CYCLES    = 40;
    localparam int     MAX_REPORTS    = 10;

    // Transaction layouts, first field in the low bits
    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] vd;
        logic [15:0] vq;
    } volt_cmd_t;

    typedef struct packed {
        logic [15:0] c;
        logic [15:0] b;
        logic [15:0] a;
    } cmp_trio_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [47:0]                     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [47:0]                     m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spmc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers
    logic [spmc_pkg::BUS_W-1:0] bus_v  = spmc_pkg::BUS_VOLTAGE_RST;
    logic [spmc_pkg::MPV_W-1:0] mpv    = spmc_pkg::MAX_PHASE_VOLTAGE_RST;
    logic [spmc_pkg::PER_W-1:0] period = spmc_pkg::PWM_PERIOD_RST;

    longint    sine_rom [0:TAB_N];
    volt_cmd_t pending_cmds [$];
    cmp_trio_t compare_queue [$];

    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    bit  s_fired       = 1'b0;
    int  n_err         = 0;
    int  n_items       = 0;
    int  n_results     = 0;
    int  n_cfg_writes  = 0;
    int  idle_cycles   = 0;

    sine_pwm_midpoint_clamp i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Quarter-wave sine entry, Q28 Taylor series rounded to Q1.15
    function automatic longint sine_value(int k);
        longint unsigned x, x2, mag, v;
        longint          sum;
        x   = (PI_Q28_TB * k) / (2 * TAB_N);
        x2  = (x * x) >> 28;
        mag = x;
        sum = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            mag = ((mag * x2) >> 28) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(mag);
            end else begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ($unsigned(sum) * 64'd32767 + (64'd1 << 27)) >> 28;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return longint'(v);
    endfunction

    // Inverse Park, inverse Clarke, midpoint clamp and duty scaling
    function automatic cmp_trio_t predict_compares(volt_cmd_t cmd);
        longint          vq, vd, lo, hi, sn, cs, alpha, beta, mn, mx, shift, w;
        longint          ph [3];
        longint unsigned ang, quad, p, idx, den;
        logic [15:0]     cmp [3];
        cmp_trio_t       res;
        vq   = longint'($signed(cmd.vq));
        vd   = longint'($signed(cmd.vd));
        ang  = 64'(cmd.angle) & ((64'd1 << ANG_BITS) - 1);
        quad = (ang >> (ANG_BITS - 2)) & 64'd3;
        p    = ang & ((64'd1 << (ANG_BITS - 2)) - 1);
        idx  = (p * TAB_N) >> (ANG_BITS - 2);
        if (idx > TAB_N) begin
            idx = TAB_N;
        end
        lo = sine_rom[int'(idx)];
        hi = sine_rom[TAB_N - int'(idx)];
        case (quad)
            0: begin sn = lo;  cs = hi;  end
            1: begin sn = hi;  cs = -lo; end
            2: begin sn = -lo; cs = -hi; end
            default: begin sn = -hi; cs = lo; end
        endcase
        alpha = cs * vd - sn * vq;
        beta  = sn * vd + cs * vq;
        ph[0] = alpha * 32768;
        ph[1] = -alpha * 16384 + SQRT3_HALF * beta;
        ph[2] = -alpha * 16384 - SQRT3_HALF * beta;
        mn = ph[0];
        mx = ph[0];
        for (int i = 1; i < 3; i++) begin
            if (ph[i] < mn) mn = ph[i];
            if (ph[i] > mx) mx = ph[i];
        end
        shift = (longint'(mpv) <<< 30) - (mx + mn);
        den   = 64'(bus_v) << 31;
        // Saturate to 0..period; zero bus voltage never divides
        for (int i = 0; i < 3; i++) begin
            w = 2 * ph[i] + shift;
            if (w <= 0) begin
                cmp[i] = '0;
            end else if ($unsigned(w) >= den) begin
                cmp[i] = period;
            end else begin
                cmp[i] = 16'(($unsigned(w) * 64'(period)) / den);
            end
        end
        res.a = cmp[0];
        res.b = cmp[1];
        res.c = cmp[2];
        return res;
    endfunction

    function automatic logic [15:0] rand_volt();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(4095)) - 16'd2048;
            2: return 16'($urandom_range(16383)) - 16'd8192;
            default: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(7))
            0: return {2'($urandom_range(3)), 14'h0000};
            1: return {2'($urandom_range(3)), 14'h3FFF};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_cmd(input logic [15:0] q, input logic [15:0] d,
                            input logic [15:0] ang);
        volt_cmd_t cmd;
        cmd.vq    = q;
        cmd.vd    = d;
        cmd.angle = ang;
        pending_cmds.push_back(cmd);
    endtask

    // Wait until every queued command went in and its result came back
    task automatic drain_results();
        while (pending_cmds.size() != 0 || compare_queue.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // One register write transaction; the predictor copy follows on acceptance
    task automatic write_reg(input logic [spmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            spmc_pkg::REG_BUS_VOLTAGE:       bus_v  = data[spmc_pkg::BUS_W-1:0];
            spmc_pkg::REG_MAX_PHASE_VOLTAGE: mpv    = data[spmc_pkg::MPV_W-1:0];
            spmc_pkg::REG_PWM_PERIOD:        period = data[spmc_pkg::PER_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Register settings per phase: reset, extremes, zero period, random, reset again
    task automatic configure(input int ph);
        case (ph)
            1: begin
                write_reg(spmc_pkg::REG_BUS_VOLTAGE, 16'h8001);
                write_reg(spmc_pkg::REG_MAX_PHASE_VOLTAGE, 16'h7FFF);
                write_reg(spmc_pkg::REG_PWM_PERIOD, 16'hFFFF);
            end
            2: begin
                write_reg(spmc_pkg::REG_BUS_VOLTAGE, 16'h7FFF);
                write_reg(spmc_pkg::REG_MAX_PHASE_VOLTAGE, 16'h8000);
                write_reg(spmc_pkg::REG_PWM_PERIOD, 16'd1);
            end
            3: begin
                write_reg(spmc_pkg::REG_BUS_VOLTAGE, 16'h8000);
                write_reg(spmc_pkg::REG_MAX_PHASE_VOLTAGE, 16'd3072);
                write_reg(spmc_pkg::REG_PWM_PERIOD, 16'd1000);
            end
            4: begin
                write_reg(spmc_pkg::REG_BUS_VOLTAGE, 16'd3072);
                write_reg(spmc_pkg::REG_PWM_PERIOD, 16'd0);
                write_reg(REG_NONE, 16'($urandom));
            end
            5, 6: begin
                write_reg(spmc_pkg::REG_BUS_VOLTAGE,
                          {1'($urandom_range(1)), 15'($urandom_range(1, 32767))});
                write_reg(spmc_pkg::REG_MAX_PHASE_VOLTAGE, 16'($urandom));
                write_reg(spmc_pkg::REG_PWM_PERIOD, 16'($urandom_range(1, 65535)));
                write_reg(REG_NONE, 16'($urandom));
            end
            7: begin
                write_reg(spmc_pkg::REG_BUS_VOLTAGE, 16'(spmc_pkg::BUS_VOLTAGE_RST));
                write_reg(spmc_pkg::REG_MAX_PHASE_VOLTAGE,
                          16'(spmc_pkg::MAX_PHASE_VOLTAGE_RST));
                write_reg(spmc_pkg::REG_PWM_PERIOD, spmc_pkg::PWM_PERIOD_RST);
            end
            default: ;
        endcase
    endtask

    // Predict on input transactions, check result transactions
    always @(posedge aclk) begin : monitor
        cmp_trio_t want;
        cmp_trio_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                compare_queue.push_back(predict_compares(volt_cmd_t'(s_tdata)));
                void'(pending_cmds.pop_front());
                n_items++;
            end
            if (m_tvalid && m_tready) begin
                got = cmp_trio_t'(m_tdata);
                n_results++;
                if (compare_queue.size() == 0) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS) begin
                        $display("unexpected result a=%0d b=%0d c=%0d", got.a, got.b, got.c);
                    end
                end else begin
                    want = compare_queue.pop_front();
                    if (got.a !== want.a || got.b !== want.b || got.c !== want.c) begin
                        n_err++;
                        if (n_err <= MAX_REPORTS) begin
                            $display({"mismatch #%0d: expected a=%0d b=%0d c=%0d, ",
                                      "got a=%0d b=%0d c=%0d"},
                                     n_results, want.a, want.b, want.c, got.a, got.b, got.c);
                        end
                    end
                end
            end
        end
        s_fired = aresetn && s_tvalid && s_tready;
    end

    // Drive input transactions and receiver backpressure on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fired) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_cmds[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= snk_stall_pct);
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int i;
        int ph;
        for (i = 0; i <= TAB_N; i++) begin
            sine_rom[i] = sine_value(i);
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, quadrant edges, saturation and in-range duty
        push_cmd(16'h0000, 16'h0000, 16'h0000);
        push_cmd(16'h7FFF, 16'h0000, 16'h0000);
        push_cmd(16'h8000, 16'h0000, 16'h0000);
        push_cmd(16'h0000, 16'h7FFF, 16'h0000);
        push_cmd(16'h0000, 16'h8000, 16'h0000);
        push_cmd(16'h7FFF, 16'h7FFF, 16'h4000);
        push_cmd(16'h8000, 16'h8000, 16'h8000);
        push_cmd(16'h7FFF, 16'h8000, 16'hC000);
        push_cmd(16'h8000, 16'h7FFF, 16'hFFFF);
        push_cmd(16'h0300, 16'h0000, 16'h3FFF);
        push_cmd(16'h0300, 16'h0100, 16'h2000);
        push_cmd(16'h0100, 16'h0000, 16'h0040);
        push_cmd(16'h0100, 16'h0100, 16'h003F);
        push_cmd(16'h0200, 16'hFF00, 16'h5555);
        push_cmd(16'hFFFF, 16'h0001, 16'hAAAA);
        push_cmd(16'h0C00, 16'h0000, 16'hE000);
        push_cmd(16'hF400, 16'h0400, 16'h7FFF);
        push_cmd(16'h0080, 16'hFF80, 16'hBFFF);
        drain_results();

        // Random phases, each with its own settings and idle pattern
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            configure(ph);
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 9; snk_stall_pct = 9; end
            endcase
            for (i = 0; i < RAND_PER_PHASE; i++) begin
                push_cmd(rand_volt(), rand_volt(), rand_angle());
                // Hold the sender mid-phase until the pipeline has emptied
                if (ph == 2 && i == RAND_PER_PHASE / 2) begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (compare_queue.size() != 0) begin
            n_err++;
        end
        $display("Run: %0d voltage transactions, %0d compare results, %0d register writes",
                 n_items, n_results, n_cfg_writes);
        $display("Settings swept: reset, extremes, zero bus and zero period, random; %0d errors",
                 n_err);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
